// ===== rtl/zfhwc_pkg.sv =====
// Shared types, codes and helper functions for the frame header window check.
// No dependencies; the core, capture and verdict files import this package.
`default_nettype none
package zfhwc_pkg;

  localparam int CntW = 5;

  localparam logic [31:0] FrameMagic  = 32'hFD2FB528;
  localparam logic [31:0] SkipMask    = 32'hFFFFFFF0;
  localparam logic [31:0] SkipBase    = 32'h184D2A50;
  localparam logic [31:0] WindowReset = 32'd8388608;
  localparam logic [7:0]  SingleSeg   = 8'h20;
  localparam logic [63:0] Fcs2Offset  = 64'd256;

  typedef enum logic [2:0] {
    V_REGULAR   = 3'd0,
    V_SKIPPABLE = 3'd1,
    V_SHORT     = 3'd2,
    V_MAGIC     = 3'd3,
    V_TRUNC     = 3'd4,
    V_BIG       = 3'd5
  } verdict_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic [31:0]     lead;
    logic [7:0]      desc;
    logic [7:0]      wcode;
    logic [63:0]     fcs;
  } frame_t;

  // frame content size field length in bytes
  function automatic logic [CntW-1:0] fcs_len(input logic [7:0] desc);
    logic [CntW-1:0] len;
    begin
      unique case (desc[7:6])
        2'd0:    len = CntW'(1);
        2'd1:    len = CntW'(2);
        2'd2:    len = CntW'(4);
        default: len = CntW'(8);
      endcase
      return len;
    end
  endfunction

  // offset of the content size field: after magic, descriptor and dict id, with no window byte
  function automatic logic [CntW-1:0] fcs_off(input logic [7:0] desc);
    logic [CntW-1:0] off;
    begin
      unique case (desc[1:0])
        2'd0:    off = CntW'(5);
        2'd1:    off = CntW'(6);
        2'd2:    off = CntW'(7);
        default: off = CntW'(9);
      endcase
      return off;
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/zfhwc_if.sv =====
// Valid/ready channel interfaces: header bytes in, verdict items out.
// Depends on nothing; the verdict width is written out here as three bits.
`default_nettype none
interface zfhwc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       last_byte;

  modport source (output valid, output header_byte, output last_byte, input ready);
  modport sink   (input valid, input header_byte, input last_byte, output ready);
endinterface

interface zfhwc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [63:0] declared_window;

  modport source (output valid, output verdict, output declared_window, input ready);
  modport sink   (input valid, input verdict, input declared_window, output ready);
endinterface
`default_nettype wire

// ===== rtl/zstd_frame_header_window_check_core.sv =====
// Top level of the frame header window check: config register and the
// capture and verdict stages. Uses zfhwc_pkg, zfhwc_if, zfhwc_collect, zfhwc_judge.
//
// Usage:
//   bytes  : header bytes of a file, offset zero first; last_byte marks the
//            final byte. Only the first PROBE_BYTES bytes are stored.
//   result : one item per file, given for the byte with last_byte set:
//            verdict and the declared window (zero unless regular or too big).
//   cfg_we / cfg_wdata : write max_window (reset 8388608); write while idle.
// Throughput is one byte per cycle while bytes is not stalled. A frame
// passes the capture snapshot register, then the result register.
// When result stalls, the result register holds, the snapshot register
// fills with the next frame, and bytes stalls only once both are full;
// non-last bytes keep flowing only while the snapshot slot is free.
// Reset clears the frame state, empties both stages and restores max_window.
`default_nettype none
module zstd_frame_header_window_check_core #(
  parameter int PROBE_BYTES = 18
) (
  input  wire logic        clk,
  input  wire logic        rst,
  zfhwc_in_if.sink         bytes,
  zfhwc_out_if.source      result,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);
  import zfhwc_pkg::*;

  logic [31:0] max_window;
  frame_t      snap;
  logic        snap_valid;
  logic        snap_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_window <= WindowReset;
    end else if (cfg_we) begin
      max_window <= cfg_wdata;
    end
  end

  zfhwc_collect #(
    .PROBE_BYTES (PROBE_BYTES)
  ) u_collect (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .snap       (snap),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready)
  );

  zfhwc_judge u_judge (
    .clk        (clk),
    .rst        (rst),
    .snap       (snap),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .max_window (max_window),
    .result     (result)
  );

endmodule
`default_nettype wire

// ===== rtl/zfhwc_collect.sv =====
// Byte capture: builds the frame state one byte per item and hands a
// snapshot of it downstream on the last byte. Uses zfhwc_pkg, zfhwc_in_if.
`default_nettype none
module zfhwc_collect #(
  parameter int PROBE_BYTES = 18
) (
  input  wire logic              clk,
  input  wire logic              rst,
  zfhwc_in_if.sink               bytes,
  output zfhwc_pkg::frame_t      snap,
  output logic                   snap_valid,
  input  wire logic              snap_ready
);
  import zfhwc_pkg::*;

  frame_t          frame;
  frame_t          frame_next;
  logic            accept;
  logic [CntW-1:0] off;
  logic [CntW-1:0] len;
  logic [CntW-1:0] rel;

  assign bytes.ready = !snap_valid || snap_ready;
  assign accept      = bytes.valid && bytes.ready;

  assign off = fcs_off(frame.desc);
  assign len = fcs_len(frame.desc);
  assign rel = frame.count - off;

  always_comb begin
    frame_next = frame;
    if (frame.count < CntW'(PROBE_BYTES)) begin
      frame_next.count = frame.count + CntW'(1);
      if (frame.count < CntW'(4)) begin
        frame_next.lead[8*frame.count[1:0] +: 8] = bytes.header_byte;
      end
      if (frame.count == CntW'(4)) begin
        frame_next.desc = bytes.header_byte;
      end
      if (frame.count == CntW'(5)) begin
        frame_next.wcode = bytes.header_byte;
      end
      if (frame.count >= CntW'(5) && frame.count >= off && frame.count < off + len) begin
        frame_next.fcs[8*rel[2:0] +: 8] = bytes.header_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame      <= '0;
      snap_valid <= 1'b0;
    end else begin
      if (accept && bytes.last_byte) begin
        snap_valid <= 1'b1;
      end else if (snap_valid && snap_ready) begin
        snap_valid <= 1'b0;
      end
      if (accept) begin
        if (bytes.last_byte) begin
          frame <= '0;
        end else begin
          frame <= frame_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && bytes.last_byte) begin
      snap <= frame_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/zfhwc_judge.sv =====
// Verdict logic and result register: classifies one frame snapshot and
// holds the item until taken. Uses zfhwc_pkg, zfhwc_out_if.
`default_nettype none
module zfhwc_judge (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire zfhwc_pkg::frame_t snap,
  input  wire logic              snap_valid,
  output logic                   snap_ready,
  input  wire logic [31:0]       max_window,
  zfhwc_out_if.source            result
);
  import zfhwc_pkg::*;

  verdict_t    v;
  verdict_t    v_reg;
  logic [63:0] win;
  logic [63:0] desc_win;
  logic [63:0] base;
  logic [63:0] fcs_win;
  logic [2:0]  mant;
  logic [5:0]  expo;
  logic        out_v;
  logic        load;

  assign mant = snap.wcode[2:0];
  assign expo = 6'd10 + {1'b0, snap.wcode[7:3]};
  assign base = 64'd1 << expo;
  assign desc_win = base + (mant[0] ? (base >> 3) : 64'd0)
                         + (mant[1] ? (base >> 2) : 64'd0)
                         + (mant[2] ? (base >> 1) : 64'd0);
  assign fcs_win = (snap.desc[7:6] == 2'd1) ? snap.fcs + Fcs2Offset : snap.fcs;

  always_comb begin
    v   = V_REGULAR;
    win = '0;
    if (snap.count < CntW'(4)) begin
      v = V_SHORT;
    end else if (snap.lead != FrameMagic) begin
      v = ((snap.lead & SkipMask) == SkipBase) ? V_SKIPPABLE : V_MAGIC;
    end else if (snap.count < CntW'(5)) begin
      v = V_TRUNC;
    end else if ((snap.desc & SingleSeg) == 8'd0) begin
      if (snap.count < CntW'(6)) begin
        v = V_TRUNC;
      end else begin
        win = desc_win;
      end
    end else if (snap.count < fcs_off(snap.desc) + fcs_len(snap.desc)) begin
      v = V_TRUNC;
    end else begin
      win = fcs_win;
    end
    if (v == V_REGULAR && win > {32'd0, max_window}) begin
      v = V_BIG;
    end
  end

  assign load       = snap_valid && (!out_v || result.ready);
  assign snap_ready = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (load) begin
      out_v <= 1'b1;
    end else if (result.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      v_reg                  <= v;
      result.declared_window <= win;
    end
  end

  assign result.valid   = out_v;
  assign result.verdict = v_reg;

  a_zero_window: assert property (@(posedge clk) disable iff (rst)
    out_v && !(v_reg == V_REGULAR || v_reg == V_BIG) |-> result.declared_window == 64'd0)
    else $error("window not zero for a non-regular verdict");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> out_v)
    else $error("loaded item not presented");

  a_short: assert property (@(posedge clk) disable iff (rst)
    load && snap.count < CntW'(4) |=> v_reg == V_SHORT)
    else $error("short file not reported as short");

endmodule
`default_nettype wire
